// ===== hdl/pts_pkg.sv =====
// Package for the priority task scheduler: sizes, operation codes,
// table access structs and small helper functions.
// No dependencies.
`default_nettype none

package pts_pkg;

  // Table sizes
  localparam int MAX_TASKS  = 8;
  localparam int MAX_LEVELS = 8;

  localparam int SLOT_W  = $clog2(MAX_TASKS);
  localparam int LVL_W   = $clog2(MAX_LEVELS);
  localparam int TOT_W   = $clog2(MAX_TASKS + 1);
  localparam int DIST_W  = SLOT_W + 1;
  localparam int DELAY_W = 32;
  localparam int TICK_W  = 32;

  // Operation codes
  localparam logic [1:0] OP_CREATE = 2'd0;
  localparam logic [1:0] OP_DELAY  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_SWITCH = 2'd3;

  // Status codes
  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  // Write port bundle into the task table
  typedef struct packed {
    logic               pri_we;
    logic [SLOT_W-1:0]  pri_addr;
    logic [LVL_W-1:0]   pri_data;
    logic               dly_we;
    logic [SLOT_W-1:0]  dly_addr;
    logic [DELAY_W-1:0] dly_data;
    logic               lst_we;
    logic [LVL_W-1:0]   lst_addr;
    logic [SLOT_W-1:0]  lst_data;
  } tbl_wr_t;

  // Read data for the slot under scan
  typedef struct packed {
    logic [LVL_W-1:0]   pri;
    logic [DELAY_W-1:0] dly;
    logic [SLOT_W-1:0]  last;
  } tbl_rd_t;

  // Best candidate so far in a switch scan
  typedef struct packed {
    logic              found;
    logic [LVL_W-1:0]  pri;
    logic [SLOT_W-1:0] rr_pos;
  } best_t;

  // Result of the shared evaluate unit
  typedef struct packed {
    logic               dly_wr;
    logic [DELAY_W-1:0] dly_dec;
    logic               better;
    logic [SLOT_W-1:0]  rr_pos;
  } eval_t;

  // Low three bits of a slot index, zero extended when the index is narrower
  function automatic logic [2:0] slot_low3(input logic [SLOT_W-1:0] s);
    logic [SLOT_W+2:0] w;
    w = {3'b000, s};
    return w[2:0];
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pts_if.sv =====
// Channel interfaces of the priority task scheduler: request and result.
// Valid/ready handshake; no package dependencies.
`default_nettype none

interface pts_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  priority_req;
  logic [31:0] delay_ticks;

  modport source (output valid, operation, priority_req, delay_ticks, input ready);
  modport sink   (input valid, operation, priority_req, delay_ticks, output ready);
endinterface

interface pts_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  current_task;
  logic        current_valid;
  logic [2:0]  created_task;
  logic        status;
  logic [31:0] tick_now;

  modport source (output valid, current_task, current_valid, created_task, status,
                  tick_now, input ready);
  modport sink   (input valid, current_task, current_valid, created_task, status,
                  tick_now, output ready);
endinterface

`default_nettype wire

// ===== hdl/priority_task_scheduler.sv =====
// Top level of the priority task scheduler: sequencer, state registers and
// result register. Depends on pts_pkg, pts_if, pts_task_table, pts_eval_unit.
//
//  Channel  | Direction | Contents
//  ---------+-----------+--------------------------------------------------
//  in_ch    | sink      | operation, priority_req, delay_ticks
//  out_ch   | source    | current_task, current_valid, created_task, status,
//           |           | tick_now
//
// Create and delay: accepted in idle, then the done state publishes the result.
// Tick and switch: the slot scan runs one slot per cycle through the shared
// evaluate unit, then the done state publishes the result.
// One transaction is in work at a time; a new one is taken while the result
// register still waits on out_ch.ready, and a finished one holds until that
// register frees. Reset is synchronous, needs no pass.
`default_nettype none

module priority_task_scheduler
  import pts_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  pts_in_if.sink    in_ch,
  pts_out_if.source out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [1:0]         op_r;
  logic [SLOT_W-1:0]  idx_r, idx_nxt;
  logic [TOT_W-1:0]   total_r;
  logic [SLOT_W-1:0]  run_slot_r;
  logic [LVL_W-1:0]   run_pri_r;
  logic               run_valid_r;
  logic [TICK_W-1:0]  tick_r;
  logic [SLOT_W-1:0]  created_r;
  logic               status_r;
  best_t              best_r, best_nxt;
  logic [SLOT_W-1:0]  best_slot_r, best_slot_nxt;

  logic               out_valid_r;
  logic [2:0]         out_cur_r;
  logic               out_cur_valid_r;
  logic [2:0]         out_created_r;
  logic               out_status_r;
  logic [TICK_W-1:0]  out_tick_r;

  logic               in_acc;
  logic               full;
  logic               scan_last;
  logic               publish;
  logic [LVL_W-1:0]   req_lvl;
  logic [SLOT_W-1:0]  free_slot;
  tbl_wr_t            wr;
  tbl_rd_t            rd;
  eval_t              ev;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign full        = (total_r == TOT_W'(MAX_TASKS));
  assign free_slot   = total_r[SLOT_W-1:0];
  assign scan_last   = (idx_r == SLOT_W'(MAX_TASKS - 1));
  assign publish     = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign req_lvl     = (in_ch.priority_req >= 8'(MAX_LEVELS)) ?
                       LVL_W'(MAX_LEVELS - 1) : in_ch.priority_req[LVL_W-1:0];

  pts_task_table u_table (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (wr),
    .rd_idx (idx_r),
    .rd     (rd)
  );

  pts_eval_unit u_eval (
    .idx   (idx_r),
    .total (total_r),
    .rd    (rd),
    .best  (best_r),
    .ev    (ev)
  );

  // Best candidate including the slot under scan
  always_comb begin
    best_nxt      = best_r;
    best_slot_nxt = best_slot_r;
    if (ev.better) begin
      best_nxt.found  = 1'b1;
      best_nxt.pri    = rd.pri;
      best_nxt.rr_pos = ev.rr_pos;
      best_slot_nxt   = idx_r;
    end
  end

  // Table write port
  always_comb begin
    wr = '0;
    if (in_acc && (in_ch.operation == OP_CREATE) && !full) begin
      wr.pri_we   = 1'b1;
      wr.pri_addr = free_slot;
      wr.pri_data = req_lvl;
      wr.dly_we   = 1'b1;
      wr.dly_addr = free_slot;
      wr.dly_data = '0;
    end else if (in_acc && (in_ch.operation == OP_DELAY) && run_valid_r) begin
      wr.dly_we   = 1'b1;
      wr.dly_addr = run_slot_r;
      wr.dly_data = in_ch.delay_ticks;
    end else if ((state_r == ST_SCAN) && (op_r == OP_TICK)) begin
      wr.dly_we   = ev.dly_wr;
      wr.dly_addr = idx_r;
      wr.dly_data = ev.dly_dec;
    end else if ((state_r == ST_SCAN) && scan_last && best_nxt.found) begin
      wr.lst_we   = 1'b1;
      wr.lst_addr = best_nxt.pri;
      wr.lst_data = best_slot_nxt;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          idx_nxt = '0;
          if ((in_ch.operation == OP_TICK) || (in_ch.operation == OP_SWITCH)) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        idx_nxt = idx_r + SLOT_W'(1);
        if (scan_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (publish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and scheduler state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      total_r     <= '0;
      run_slot_r  <= '0;
      run_valid_r <= 1'b0;
      tick_r      <= '0;
      best_r      <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      if (in_acc) begin
        best_r <= '0;
        case (in_ch.operation)
          OP_CREATE: begin
            if (!full) begin
              total_r <= total_r + TOT_W'(1);
              if (!run_valid_r || (run_pri_r <= req_lvl)) begin
                run_slot_r  <= free_slot;
                run_valid_r <= 1'b1;
              end
            end
          end
          OP_TICK: begin
            tick_r <= tick_r + TICK_W'(1);
          end
          default: begin
          end
        endcase
      end else if ((state_r == ST_SCAN) && (op_r == OP_SWITCH)) begin
        best_r <= best_nxt;
        if (scan_last && best_nxt.found) begin
          run_slot_r  <= best_slot_nxt;
          run_valid_r <= 1'b1;
        end
      end
    end
  end

  // Transaction payload and running priority
  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r      <= in_ch.operation;
      created_r <= '0;
      status_r  <= STATUS_OK;
      if (in_ch.operation == OP_CREATE) begin
        if (full) begin
          status_r <= STATUS_FULL;
        end else begin
          created_r <= free_slot;
          if (!run_valid_r || (run_pri_r <= req_lvl)) begin
            run_pri_r <= req_lvl;
          end
        end
      end
    end else if ((state_r == ST_SCAN) && (op_r == OP_SWITCH)) begin
      best_slot_r <= best_slot_nxt;
      if (scan_last && best_nxt.found) begin
        run_pri_r <= best_nxt.pri;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (publish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (publish) begin
      out_cur_r       <= run_valid_r ? slot_low3(run_slot_r) : 3'd0;
      out_cur_valid_r <= run_valid_r;
      out_created_r   <= slot_low3(created_r);
      out_status_r    <= status_r;
      out_tick_r      <= tick_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.current_task  = out_cur_r;
  assign out_ch.current_valid = out_cur_valid_r;
  assign out_ch.created_task  = out_created_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.tick_now      = out_tick_r;

endmodule

`default_nettype wire

// ===== hdl/pts_task_table.sv =====
// Task table storage: per-slot priority and delay, per-level last served slot.
// Depends on pts_pkg.
`default_nettype none

module pts_task_table
  import pts_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  tbl_wr_t           wr,
  input  logic [SLOT_W-1:0] rd_idx,
  output tbl_rd_t           rd
);

  logic [LVL_W-1:0]   pri_mem [MAX_TASKS];
  logic [DELAY_W-1:0] dly_mem [MAX_TASKS];
  logic [SLOT_W-1:0]  lst_r   [MAX_LEVELS];

  // Priority and delay are written before a slot is ever read as used
  always_ff @(posedge clk) begin
    if (wr.pri_we) begin
      pri_mem[wr.pri_addr] <= wr.pri_data;
    end
    if (wr.dly_we) begin
      dly_mem[wr.dly_addr] <= wr.dly_data;
    end
  end

  // Round robin pointers, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        lst_r[i] <= '0;
      end
    end else if (wr.lst_we) begin
      lst_r[wr.lst_addr] <= wr.lst_data;
    end
  end

  // Read side for the slot under scan
  always_comb begin
    rd.pri  = pri_mem[rd_idx];
    rd.dly  = dly_mem[rd_idx];
    rd.last = lst_r[rd.pri];
  end

endmodule

`default_nettype wire

// ===== hdl/pts_eval_unit.sv =====
// Shared slot evaluate unit: delay decrement for ticks and the priority /
// round robin distance compare for switches. Depends on pts_pkg.
`default_nettype none

module pts_eval_unit
  import pts_pkg::*;
(
  input  logic [SLOT_W-1:0] idx,
  input  logic [TOT_W-1:0]  total,
  input  tbl_rd_t           rd,
  input  best_t             best,
  output eval_t             ev
);

  logic              used;
  logic              rdy;
  logic [DIST_W-1:0] span;
  logic [DIST_W-1:0] wrapped;
  logic [SLOT_W-1:0] rr_pos;

  always_comb begin
    // slots fill from zero and are never freed
    used = TOT_W'(idx) < total;
    rdy  = used && (rd.dly == '0);

    // cyclic distance from the slot after the level's last served one
    span    = DIST_W'(idx) + DIST_W'(MAX_TASKS) - DIST_W'(rd.last) - DIST_W'(1);
    wrapped = (span >= DIST_W'(MAX_TASKS)) ? span - DIST_W'(MAX_TASKS) : span;
    rr_pos  = wrapped[SLOT_W-1:0];

    ev.rr_pos  = rr_pos;
    ev.dly_dec = rd.dly - DELAY_W'(1);
    ev.dly_wr  = used && (rd.dly != '0);
    ev.better  = rdy && (!best.found || (rd.pri > best.pri) ||
                         ((rd.pri == best.pri) && (rr_pos < best.rr_pos)));
  end

endmodule

`default_nettype wire

// ===== hdl/pts_checker.sv =====
// Port-level checker for the priority task scheduler, bound to the top level.
// Depends on pts_if signals only through the bind connections.
`default_nettype none

module pts_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [2:0]  out_current_task,
  input  logic        out_current_valid,
  input  logic [2:0]  out_created_task,
  input  logic        out_status,
  input  logic [31:0] out_tick_now
);

  logic        in_acc;
  logic        out_acc;
  logic [1:0]  pend_r;
  logic        seen_cur_r;
  logic        have_tick_r;
  logic [31:0] last_tick_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Transactions taken but not yet answered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      seen_cur_r  <= 1'b0;
      have_tick_r <= 1'b0;
      last_tick_r <= '0;
    end else begin
      if (in_acc && !out_acc) begin
        pend_r <= pend_r + 2'd1;
      end else if (!in_acc && out_acc) begin
        pend_r <= pend_r - 2'd1;
      end
      if (out_acc) begin
        have_tick_r <= 1'b1;
        last_tick_r <= out_tick_now;
        if (out_current_valid) begin
          seen_cur_r <= 1'b1;
        end
      end
    end
  end

  // A result is never shown without a transaction behind it
  a_no_orphan_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (pend_r != 2'd0))
    else $error("result shown with no pending transaction");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid &&
      $stable({out_current_task, out_current_valid, out_created_task, out_status,
               out_tick_now}))
    else $error("result changed while stalled");

  // Once a task runs there is always a current task
  a_current_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && seen_cur_r |-> out_current_valid)
    else $error("current task lost");

  // Tick count moves by at most one per transaction
  a_tick_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && have_tick_r |->
      (out_tick_now == last_tick_r) || (out_tick_now == last_tick_r + 32'd1))
    else $error("tick count jumped");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_current_task  (out_ch.current_task),
  .out_current_valid (out_ch.current_valid),
  .out_created_task  (out_ch.created_task),
  .out_status        (out_ch.status),
  .out_tick_now      (out_ch.tick_now)
);

`default_nettype wire

// ===== tb/pts_result_checker.sv =====
// Scoreboard for the priority task scheduler: watches both channels, predicts
// each result from its own copy of the task table and compares field by field.
// Depends on pts_pkg and the channel interfaces in pts_if.
module pts_result_checker
  import pts_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  pts_in_if    in_mon,
  pts_out_if   out_mon,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [2:0]  current_task;
    logic        current_valid;
    logic [2:0]  created_task;
    logic        status;
    logic [31:0] tick_now;
  } sched_result_t;

  // Predicted scheduler state
  logic              task_used  [MAX_TASKS];
  logic [LVL_W-1:0]  task_level [MAX_TASKS];
  logic [31:0]       task_delay [MAX_TASKS];
  logic [SLOT_W-1:0] level_last [MAX_LEVELS];
  logic [SLOT_W-1:0] run_slot;
  logic              run_valid;
  logic [31:0]       tick_count;

  sched_result_t expected_results [$];

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < 100)
      $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic clear_schedule();
    int i;
    for (i = 0; i < MAX_TASKS; i++) begin
      task_used[i]  = 1'b0;
      task_level[i] = '0;
      task_delay[i] = '0;
    end
    for (i = 0; i < MAX_LEVELS; i++)
      level_last[i] = '0;
    run_slot   = '0;
    run_valid  = 1'b0;
    tick_count = '0;
  endtask

  // Apply one request to the predicted table and form its result
  task automatic advance_schedule(input logic [1:0] op, input logic [7:0] pri_req,
                                  input logic [31:0] dly, output sched_result_t res);
    int               s;
    int               k;
    int               lvl;
    int               slot;
    logic [LVL_W-1:0] level;
    logic             picked;
    res        = '0;
    res.status = STATUS_OK;
    case (op)
      OP_CREATE: begin
        // lowest free slot
        slot = -1;
        for (s = MAX_TASKS - 1; s >= 0; s--)
          if (!task_used[s]) slot = s;
        if (slot < 0) begin
          res.status = STATUS_FULL;
        end else begin
          level = (pri_req >= MAX_LEVELS) ? LVL_W'(MAX_LEVELS - 1) : pri_req[LVL_W-1:0];
          task_used[slot]  = 1'b1;
          task_level[slot] = level;
          task_delay[slot] = '0;
          // equal priority also pre-empts
          if (!run_valid || task_level[run_slot] <= level) begin
            run_slot  = SLOT_W'(slot);
            run_valid = 1'b1;
          end
          res.created_task = 3'(slot);
        end
      end
      OP_DELAY: begin
        if (run_valid) task_delay[run_slot] = dly;
      end
      OP_TICK: begin
        tick_count = tick_count + 32'd1;
        for (s = 0; s < MAX_TASKS; s++)
          if (task_used[s] && task_delay[s] != 0) task_delay[s] = task_delay[s] - 32'd1;
      end
      OP_SWITCH: begin
        // highest ready level first, cyclic from the level's last served slot
        picked = 1'b0;
        for (lvl = MAX_LEVELS - 1; lvl >= 0; lvl--) begin
          for (k = 1; k <= MAX_TASKS; k++) begin
            s = (int'(level_last[lvl]) + k) % MAX_TASKS;
            if (!picked && task_used[s] && int'(task_level[s]) == lvl &&
                task_delay[s] == 0) begin
              picked          = 1'b1;
              run_slot        = SLOT_W'(s);
              run_valid       = 1'b1;
              level_last[lvl] = SLOT_W'(s);
            end
          end
        end
      end
    endcase
    res.current_valid = run_valid;
    res.current_task  = run_valid ? 3'(run_slot) : 3'd0;
    res.tick_now      = tick_count;
  endtask

  // Compare results first, then predict, so a stray result is never masked
  always @(posedge clk) begin : watch
    sched_result_t got;
    sched_result_t want;
    sched_result_t fresh;
    if (!rst_n) begin
      clear_schedule();
      expected_results.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.current_task  = out_mon.current_task;
        got.current_valid = out_mon.current_valid;
        got.created_task  = out_mon.created_task;
        got.status        = out_mon.status;
        got.tick_now      = out_mon.tick_now;
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with nothing outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("current_task", 32'(got.current_task), 32'(want.current_task));
          check_field("current_valid", 32'(got.current_valid), 32'(want.current_valid));
          check_field("created_task", 32'(got.created_task), 32'(want.created_task));
          check_field("status", 32'(got.status), 32'(want.status));
          check_field("tick_now", got.tick_now, want.tick_now);
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        advance_schedule(in_mon.operation, in_mon.priority_req, in_mon.delay_ticks, fresh);
        expected_results.push_back(fresh);
      end
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== tb/priority_task_scheduler_tb.sv =====
// Testbench top for the priority task scheduler: clock, reset, request
// stimulus with bursty pacing, result back-pressure and the verdict.
// Depends on pts_pkg, pts_if, the scheduler RTL and pts_result_checker.
module priority_task_scheduler_tb
  import pts_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic     clk   = 1'b0;
  logic     rst_n = 1'b0;
  int       fails;
  int       pending;
  int       sent        = 0;
  int       burst_left  = 0;
  int       rx_left     = 0;
  int       rx_count    = 0;
  rx_mode_t rx_mode     = RX_OPEN;
  logic     mid_paused  = 1'b0;

  pts_in_if  in_ch ();
  pts_out_if out_ch ();

  priority_task_scheduler DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pts_result_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .fail_count  (fails),
    .outstanding (pending)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result back-pressure: phases of open, random and periodic stalling
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_count++;
    case (rx_mode)
      RX_OPEN:   out_ch.ready <= 1'b1;
      RX_RANDOM: out_ch.ready <= ($urandom_range(0, 2) != 0);
      default:   out_ch.ready <= ((rx_count % 5) >= 2);
    endcase
  end

  // One request transaction; a random gap follows when the burst runs out
  task automatic send_item(input logic [1:0] op, input logic [7:0] pri,
                           input logic [31:0] dly);
    int gap;
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.operation    = op;
    in_ch.priority_req = pri;
    in_ch.delay_ticks  = dly;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 1'b0;
      end
      burst_left = $urandom_range(1, 24);
    end
  endtask

  // Hold the sender until every outstanding result has come back
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int          sel;
    logic [7:0]  junk_pri;
    logic [31:0] junk_dly;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_CREATE;
    in_ch.priority_req = '0;
    in_ch.delay_ticks  = '0;
    out_ch.ready       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty table, clamping, pre-emption, delays and round robin
    send_item(OP_DELAY, 8'h00, 32'h1234_5678);   // no current task: ignored
    send_item(OP_SWITCH, 8'hFF, 32'h0);          // nothing ready
    send_item(OP_TICK, 8'h00, 32'hFFFF_FFFF);
    send_item(OP_CREATE, 8'd0, 32'h0);           // first task becomes current
    send_item(OP_CREATE, 8'd255, 32'h0);         // clamped to top level
    send_item(OP_CREATE, 8'd8, 32'h0);           // clamped, equal level pre-empts
    send_item(OP_CREATE, 8'd3, 32'h0);           // lower level, not current
    send_item(OP_DELAY, 8'h00, 32'hFFFF_FFFF);
    send_item(OP_TICK, 8'h00, 32'h0);
    send_item(OP_DELAY, 8'h00, 32'd3);           // delayed current stays current
    send_item(OP_SWITCH, 8'h00, 32'h0);
    send_item(OP_DELAY, 8'h00, 32'd0);
    send_item(OP_DELAY, 8'h00, 32'd2);
    send_item(OP_SWITCH, 8'h00, 32'h0);
    send_item(OP_DELAY, 8'h00, 32'd1);
    send_item(OP_SWITCH, 8'h00, 32'h0);
    send_item(OP_DELAY, 8'h00, 32'd1);
    send_item(OP_SWITCH, 8'h00, 32'h0);          // every task delayed
    send_item(OP_TICK, 8'h00, 32'h0);
    send_item(OP_TICK, 8'h00, 32'h0);
    send_item(OP_SWITCH, 8'h00, 32'h0);
    wait_idle();

    // Random: mostly delay/tick/switch traffic once the table has filled
    while (sent < 1950) begin
      sel      = $urandom_range(0, 99);
      junk_pri = 8'($urandom_range(0, 255));
      junk_dly = $urandom;
      if (sel < 8) begin
        send_item(OP_CREATE, ($urandom_range(0, 1) != 0) ? junk_pri :
                  8'($urandom_range(0, MAX_LEVELS - 1)), junk_dly);
      end else if (sel < 38) begin
        if ($urandom_range(0, 15) == 0) begin
          // wide value, then overwritten so the task can run again
          send_item(OP_DELAY, junk_pri, junk_dly);
          send_item(OP_DELAY, junk_pri, 32'($urandom_range(0, 12)));
        end else begin
          send_item(OP_DELAY, junk_pri, 32'($urandom_range(0, 12)));
        end
      end else if (sel < 69) begin
        send_item(OP_TICK, junk_pri, junk_dly);
      end else begin
        send_item(OP_SWITCH, junk_pri, junk_dly);
      end
      if (!mid_paused && sent >= 1000) begin
        mid_paused = 1'b1;
        wait_idle();
      end
    end

    wait_idle();
    repeat (MAX_TASKS * 4) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("** priority_task_scheduler: PASSED **");
    else
      $display("** priority_task_scheduler: FAILED **");
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("** priority_task_scheduler: FAILED **");
    $finish;
  end

endmodule
